@@ rtl/cbs_pkg.sv @@
// ---------------------------------------------------------------------------
// cbs_pkg
// Shared types and constants of the cubic B-spline segment evaluator.
// ---------------------------------------------------------------------------
package cbs_pkg;

  localparam int MAX_POINTS_DEF  = 64;
  localparam int MAX_SAMPLES_DEF = 64;

  localparam int CNT_W   = 7;   // sample_count and point_count
  localparam int IDX_W   = 6;   // point_index and segment_start
  localparam int COORD_W = 16;  // Q2.13 coordinates
  localparam int T_W     = 17;  // t in Q0.16 plus one bit for 1.0
  localparam int PADDR_W = 4;

  localparam logic [T_W-1:0] T_ONE = 17'h10000;

  // floor(x/3) = (x * RECIP3) >> RECIP3_SH, exact for x < 2^19
  localparam logic [18:0] RECIP3    = 19'd349526;
  localparam int          RECIP3_SH = 20;

  // one quotient bit per step for 65536 / d
  localparam int DIV_STEPS = 17;

  localparam logic [CNT_W-1:0] SAMPLE_COUNT_RST = 7'd64;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  localparam logic [1:0] REG_SAMPLE_COUNT = 2'd0;
  localparam logic [1:0] REG_CLOSED_LOOP  = 2'd1;
  localparam logic [1:0] REG_POINT_COUNT  = 2'd2;

  typedef struct packed {
    logic [CNT_W-1:0] sample_count;
    logic             closed_loop;
    logic [CNT_W-1:0] point_count;
  } cbs_cfg_t;

  typedef struct packed {
    logic             div_start;  // start 65536 / d
    logic             t_init;     // reset the t generator
    logic [5:0]       d;          // clamped sample_count - 1
    logic             rd_en;      // control point read
    logic [1:0]       rd_slot;
    logic [CNT_W-1:0] rd_idx;
    logic             issue;      // sample token offered
    logic             rej;        // token is a rejected segment
    logic             last;       // token closes the run
  } cbs_cmd_t;

  typedef struct packed {
    logic load_busy;   // divider or point read in flight
    logic adv;         // pipeline moves this cycle
    logic pipe_empty;  // no token left, output drained
  } cbs_stat_t;

endpackage

@@ rtl/cbs_regs.sv @@
// ---------------------------------------------------------------------------
// cbs_regs
// Configuration register file behind a simple APB-style port.
// ---------------------------------------------------------------------------
module cbs_regs
  import cbs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cbs_cfg_t           cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_count <= SAMPLE_COUNT_RST;
      cfg.closed_loop  <= 1'b0;
      cfg.point_count  <= '0;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_SAMPLE_COUNT: cfg.sample_count <= pwdata[CNT_W-1:0];
        REG_CLOSED_LOOP:  cfg.closed_loop  <= pwdata[0];
        REG_POINT_COUNT:  cfg.point_count  <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SAMPLE_COUNT: prdata = {25'd0, cfg.sample_count};
      REG_CLOSED_LOOP:  prdata = {31'd0, cfg.closed_loop};
      REG_POINT_COUNT:  prdata = {25'd0, cfg.point_count};
      default:          prdata = '0;
    endcase
  end

endmodule

@@ rtl/cbs_ctrl.sv @@
// ---------------------------------------------------------------------------
// cbs_ctrl
// Sequencer: segment check, control point fetch, sample issue and drain.
// ---------------------------------------------------------------------------
module cbs_ctrl
  import cbs_pkg::*;
#(
  parameter int MAX_POINTS  = MAX_POINTS_DEF,
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             op,
  input  logic [IDX_W-1:0] segment_start,
  input  cbs_cfg_t         cfg,
  input  cbs_stat_t        stat,
  output logic             in_stall,
  output cbs_cmd_t         cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RUN,
    ST_REJ,
    ST_DRAIN
  } state_t;

  localparam logic [10:0]      MAX_PTS_V = 11'(MAX_POINTS);
  localparam logic [CNT_W-1:0] MAX_SMP_V = CNT_W'(MAX_SAMPLES);

  state_t           state;
  logic [IDX_W-1:0] start;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] j;
  logic [2:0]       rd_cnt;

  logic [CNT_W-1:0] cnt_in;
  logic [CNT_W-1:0] n_in;
  logic [5:0]       d_in;
  logic             seg_ok;
  logic [CNT_W-1:0] k_sum;
  logic [CNT_W-1:0] k_addr;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    cnt_in = ({4'd0, cfg.point_count} > MAX_PTS_V) ? MAX_PTS_V[CNT_W-1:0] : cfg.point_count;

    if (cfg.sample_count < 7'd2) begin
      n_in = 7'd2;
    end else if (cfg.sample_count > MAX_SMP_V) begin
      n_in = MAX_SMP_V;
    end else begin
      n_in = cfg.sample_count;
    end
    d_in = 6'(n_in - 7'd1);

    if (cnt_in < 7'd4) begin
      seg_ok = 1'b0;
    end else if (cfg.closed_loop) begin
      seg_ok = {1'b0, segment_start} < cnt_in;
    end else begin
      seg_ok = {1'b0, segment_start} <= (cnt_in - 7'd4);
    end

    // index of point start + rd_cnt, wrapped once around the ring
    k_sum  = {1'b0, start} + {5'd0, rd_cnt[1:0]};
    k_addr = (k_sum >= cnt) ? (k_sum - cnt) : k_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      cmd    <= '0;
      j      <= '0;
      rd_cnt <= '0;
    end else begin
      cmd.div_start <= 1'b0;
      cmd.t_init    <= 1'b0;
      cmd.rd_en     <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_valid && op == OP_EVAL) begin
            start  <= segment_start;
            cnt    <= cnt_in;
            cmd.d  <= d_in;
            j      <= '0;
            rd_cnt <= '0;
            if (seg_ok) begin
              state         <= ST_LOAD;
              cmd.div_start <= 1'b1;
              cmd.t_init    <= 1'b1;
            end else begin
              state     <= ST_REJ;
              cmd.issue <= 1'b1;
              cmd.rej   <= 1'b1;
              cmd.last  <= 1'b1;
            end
          end
        end
        ST_LOAD: begin
          if (!rd_cnt[2]) begin
            cmd.rd_en   <= 1'b1;
            cmd.rd_slot <= rd_cnt[1:0];
            cmd.rd_idx  <= k_addr;
            rd_cnt      <= rd_cnt + 3'd1;
          end else if (!cmd.rd_en && !cmd.div_start && !stat.load_busy) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (!cmd.issue || stat.adv) begin
            if (j > {1'b0, cmd.d}) begin
              cmd.issue <= 1'b0;
              cmd.last  <= 1'b0;
              state     <= ST_DRAIN;
            end else begin
              cmd.issue <= 1'b1;
              cmd.last  <= (j == {1'b0, cmd.d});
              j         <= j + 7'd1;
            end
          end
        end
        ST_REJ: begin
          if (stat.adv) begin
            cmd.issue <= 1'b0;
            cmd.rej   <= 1'b0;
            cmd.last  <= 1'b0;
            state     <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (stat.pipe_empty) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/cbs_dpath.sv @@
// ---------------------------------------------------------------------------
// cbs_dpath
// Control point store, step divider, t generator and the sample pipeline.
// ---------------------------------------------------------------------------
module cbs_dpath
  import cbs_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic                      op,
  input  logic [IDX_W-1:0]          point_index,
  input  logic signed [COORD_W-1:0] coord_x,
  input  logic signed [COORD_W-1:0] coord_y,
  input  cbs_cmd_t                  cmd,
  output cbs_stat_t                 stat,
  input  logic                      out_stall,
  output logic                      out_valid,
  output logic signed [COORD_W-1:0] curve_x,
  output logic signed [COORD_W-1:0] curve_y,
  output logic                      valid_res,
  output logic                      last
);

  localparam int          PTR_W     = $clog2(MAX_POINTS);
  localparam logic [10:0] MAX_PTS_V = 11'(MAX_POINTS);

  // control point store
  logic [31:0]      mem [MAX_POINTS];
  logic [31:0]      mem_q;
  logic             rd_v_q;
  logic [1:0]       slot_q;
  logic [PTR_W-1:0] wr_addr;
  logic [PTR_W-1:0] rd_addr;
  logic             wr_en;

  logic signed [COORD_W-1:0] px [4];
  logic signed [COORD_W-1:0] py [4];

  // step divider
  logic [4:0]     div_cnt;
  logic [5:0]     div_rem;
  logic [T_W-1:0] div_quo;
  logic [T_W-1:0] div_dvd;
  logic [6:0]     div_sh;
  logic           div_ge;

  // t generator
  logic [T_W-1:0] q;
  logic [5:0]     r;
  logic [6:0]     r_sum;
  logic           r_wrap;

  // pipeline
  logic           adv;
  logic [6:0]     pv;
  logic [6:0]     prej;
  logic [6:0]     plast;
  logic [T_W-1:0] u1, s1, u2, s2, u3;
  logic [33:0]    uu2, ss2, uu3;
  logic [50:0]    uuu3, sss3;
  logic [52:0]    t3u3, e_t, f_t;
  logic [52:0]    n_w [4];
  logic [50:0]    num [4];
  logic [18:0]    xs [4];
  logic [36:0]    prod [4];
  logic signed [17:0] ws [4];
  logic signed [33:0] mx [4];
  logic signed [33:0] my [4];
  logic signed [35:0] ax, ay;

  function automatic logic [COORD_W-1:0] round_sat(input logic signed [35:0] a);
    logic signed [36:0] b;
    logic signed [20:0] v;
    begin
      b = 37'(a) + 37'sd32768;
      v = b[36:16];
      if (v > 21'sd32767) begin
        round_sat = 16'h7FFF;
      end else if (v < -21'sd32768) begin
        round_sat = 16'h8000;
      end else begin
        round_sat = v[15:0];
      end
    end
  endfunction

  // ---- store ----
  assign wr_addr = PTR_W'(point_index);
  assign rd_addr = PTR_W'(cmd.rd_idx);
  assign wr_en   = accept && (op == OP_WRITE) && ({5'd0, point_index} < MAX_PTS_V);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {coord_x, coord_y};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      mem_q  <= mem[rd_addr];
      slot_q <= cmd.rd_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v_q <= 1'b0;
    end else begin
      rd_v_q <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_v_q) begin
      px[slot_q] <= mem_q[31:16];
      py[slot_q] <= mem_q[15:0];
    end
  end

  // ---- 65536 / d, one quotient bit per cycle ----
  assign div_sh = {div_rem, div_dvd[T_W-1]};
  assign div_ge = div_sh >= {1'b0, cmd.d};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_start) begin
      div_cnt <= 5'(DIV_STEPS);
    end else if (div_cnt != 5'd0) begin
      div_cnt <= div_cnt - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_rem <= '0;
      div_quo <= '0;
      div_dvd <= T_ONE;
    end else if (div_cnt != 5'd0) begin
      div_rem <= div_ge ? 6'(div_sh - {1'b0, cmd.d}) : div_sh[5:0];
      div_quo <= {div_quo[T_W-2:0], div_ge};
      div_dvd <= {div_dvd[T_W-2:0], 1'b0};
    end
  end

  // ---- t = round(j * 65536 / d) by quotient and remainder steps ----
  assign r_sum  = {1'b0, r} + {1'b0, div_rem};
  assign r_wrap = r_sum >= {1'b0, cmd.d};

  always_ff @(posedge clk) begin
    if (cmd.t_init) begin
      q <= '0;
      r <= {1'b0, cmd.d[5:1]};
    end else if (cmd.issue && adv && !cmd.rej) begin
      q <= q + div_quo + T_W'(r_wrap);
      r <= r_wrap ? 6'(r_sum - {1'b0, cmd.d}) : r_sum[5:0];
    end
  end

  // ---- sample pipeline, moves as one when the output can take a beat ----
  assign adv = !out_valid || !out_stall;

  assign stat.adv        = adv;
  assign stat.load_busy  = (div_cnt != 5'd0) || rd_v_q;
  assign stat.pipe_empty = (pv == 7'd0) && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv        <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      pv        <= {pv[5:0], cmd.issue};
      out_valid <= pv[6];
    end
  end

  always_comb begin
    // numerators of 6 * 2^48 * basis, in 53 bits
    t3u3   = 53'(uuu3) + (53'(uuu3) << 1);
    e_t    = 53'(uu3) << 16;
    f_t    = 53'(u3) << 32;
    n_w[0] = 53'(sss3);
    n_w[1] = t3u3 + (53'd1 << 50) - (e_t << 1) - (e_t << 2);
    n_w[2] = e_t + (e_t << 1) + f_t + (f_t << 1) + (53'd1 << 48) - t3u3;
    n_w[3] = 53'(uuu3);
    for (int i = 0; i < 4; i++) begin
      // floor((num + 3*2^32) / 2^33)
      xs[i] = 19'(num[i][50:32]) + 19'd3;
      ws[i] = $signed({1'b0, prod[i][RECIP3_SH +: T_W]});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prej  <= {prej[5:0], cmd.rej};
      plast <= {plast[5:0], cmd.last};
      // stage 1
      u1 <= q;
      s1 <= T_ONE - q;
      // stage 2: squares
      uu2 <= {17'd0, u1} * {17'd0, u1};
      ss2 <= {17'd0, s1} * {17'd0, s1};
      u2  <= u1;
      s2  <= s1;
      // stage 3: cubes
      uuu3 <= {17'd0, uu2} * {34'd0, u2};
      sss3 <= {17'd0, ss2} * {34'd0, s2};
      uu3  <= uu2;
      u3   <= u2;
      for (int i = 0; i < 4; i++) begin
        // stage 4: basis numerators
        num[i]  <= n_w[i][50:0];
        // stage 5: divide by six via half and reciprocal of three
        prod[i] <= {19'd0, xs[i][18:1]} * {18'd0, RECIP3};
        // stage 6: weight times coordinate
        mx[i]   <= ws[i] * px[i];
        my[i]   <= ws[i] * py[i];
      end
      // stage 7: sums
      ax <= 36'(mx[0]) + 36'(mx[1]) + 36'(mx[2]) + 36'(mx[3]);
      ay <= 36'(my[0]) + 36'(my[1]) + 36'(my[2]) + 36'(my[3]);
      // output register
      curve_x   <= prej[6] ? '0 : round_sat(ax);
      curve_y   <= prej[6] ? '0 : round_sat(ay);
      valid_res <= !prej[6];
      last      <= plast[6];
    end
  end

endmodule

@@ rtl/cubic_bspline_segment_eval_core.sv @@
// ---------------------------------------------------------------------------
// cubic_bspline_segment_eval_core
// Uniform cubic B-spline evaluator over a store of 2D control points.
// ---------------------------------------------------------------------------
//
//  channel  handshake               payload
//  -------  ----------------------  ---------------------------------------
//  in       in_valid / in_stall     op, point_index, coord_x, coord_y,
//                                   segment_start
//  out      out_valid / out_stall   curve_x, curve_y, valid_res, last
//  cfg      psel / penable / pwrite paddr, pwdata, prdata, pready
//
//  a write beat does not stall; the block is ready again right after
//  an evaluate beat (n = clamped sample_count) stalls the input through setup
//    by the bit-serial 65536 / (n-1) divider and point fetch, then one sample
//    per cycle while out_stall allows into an 8 stage pipeline, then drain
//  a rejected segment gives one beat, valid_res low, through the pipeline
//  out_stall on a valid beat freezes the whole pipeline; nothing is dropped
//  synchronous reset; the point store is not cleared
// ---------------------------------------------------------------------------
module cubic_bspline_segment_eval_core
  import cbs_pkg::*;
#(
  parameter int MAX_POINTS  = MAX_POINTS_DEF,
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [PADDR_W-1:0]        paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  // input channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      op,
  input  logic [IDX_W-1:0]          point_index,
  input  logic signed [COORD_W-1:0] coord_x,
  input  logic signed [COORD_W-1:0] coord_y,
  input  logic [IDX_W-1:0]          segment_start,
  // output channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] curve_x,
  output logic signed [COORD_W-1:0] curve_y,
  output logic                      valid_res,
  output logic                      last
);

  cbs_cfg_t  cfg;
  cbs_cmd_t  cmd;
  cbs_stat_t stat;
  logic      in_accept;

  // a beat is taken only while the sequencer sits idle
  assign in_accept = in_valid && !in_stall;

  cbs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer: segment check, point fetch, sample issue, drain
  cbs_ctrl #(
    .MAX_POINTS  (MAX_POINTS),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .op            (op),
    .segment_start (segment_start),
    .cfg           (cfg),
    .stat          (stat),
    .in_stall      (in_stall),
    .cmd           (cmd)
  );

  // store, divider, t generator and the sample pipeline
  cbs_dpath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .accept      (in_accept),
    .op          (op),
    .point_index (point_index),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .cmd         (cmd),
    .stat        (stat),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .curve_x     (curve_x),
    .curve_y     (curve_y),
    .valid_res   (valid_res),
    .last        (last)
  );

endmodule

@@ test/tb_cubic_bspline_segment_eval_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_cubic_bspline_segment_eval_core
// Self-checking bench for the cubic B-spline segment evaluator: a directed
// table of point writes, segment evaluations and register writes, then
// random phases under several settings, all scored against a fixed-point
// predictor of the curve with random sender gaps and receiver stalls.
// ---------------------------------------------------------------------------
module tb_cubic_bspline_segment_eval_core
  import cbs_pkg::*;
();

  localparam int  WATCHDOG_LIMIT = 5000;   // cycles without any accepted beat
  localparam int  LONG_HOLD      = 400;    // receiver hold-off for back-pressure
  localparam int  DRAIN_CYCLES   = 100;    // > eval latency with an empty queue
  localparam int  PHASES         = 7;
  localparam int  PHASE_ITEMS    = 37;
  localparam longint unsigned T_UNIT = 64'd65536;  // t = 1.0 in q0.16

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

  // one beat on the input channel
  typedef struct {
    logic                      op;
    logic [IDX_W-1:0]          point_index;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic [IDX_W-1:0]          segment_start;
  } seg_item_t;

  // one beat on the output channel
  typedef struct {
    logic signed [COORD_W-1:0] curve_x;
    logic signed [COORD_W-1:0] curve_y;
    logic                      valid_res;
    logic                      last;
  } curve_beat_t;

  // one row of the directed table
  typedef struct {
    row_kind_t   kind;
    seg_item_t   item;
    bit          reject_typed;  // expected beat is the rejected-segment beat
    logic [1:0]  reg_id;
    logic [31:0] value;
  } dir_row_t;

  // ------------------------------------------------------------------------
  // dut signals, all inputs known from time zero
  // ------------------------------------------------------------------------
  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [PADDR_W-1:0]        paddr = '0;
  logic [31:0]               pwdata = '0;
  logic [31:0]               prdata;
  logic                      pready;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      op = OP_WRITE;
  logic [IDX_W-1:0]          point_index = '0;
  logic signed [COORD_W-1:0] coord_x = '0;
  logic signed [COORD_W-1:0] coord_y = '0;
  logic [IDX_W-1:0]          segment_start = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [COORD_W-1:0] curve_x;
  logic signed [COORD_W-1:0] curve_y;
  logic                      valid_res;
  logic                      last;

  cubic_bspline_segment_eval_core dut (
    .clk, .rst,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .op, .point_index, .coord_x, .coord_y, .segment_start,
    .out_valid, .out_stall, .curve_x, .curve_y, .valid_res, .last
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ------------------------------------------------------------------------
  // predictor state: shadow registers and the control point store
  // ------------------------------------------------------------------------
  logic [CNT_W-1:0]          cfg_samples = SAMPLE_COUNT_RST;
  logic                      cfg_closed = 1'b0;
  logic [CNT_W-1:0]          cfg_points = '0;
  logic signed [COORD_W-1:0] pt_x [MAX_POINTS_DEF];
  logic signed [COORD_W-1:0] pt_y [MAX_POINTS_DEF];
  bit                        pt_written [MAX_POINTS_DEF];

  curve_beat_t curve_exp_q [$];   // curve beats still owed by the dut
  int          mismatches = 0;
  int          out_beats = 0;
  int          burst_left = 0;    // beats left in the current sender burst
  int          hold_asks = 0;     // long receiver hold-offs requested

  // point count and sample count as the block actually uses them
  function automatic int unsigned eff_points();
    return (cfg_points > MAX_POINTS_DEF) ? MAX_POINTS_DEF : cfg_points;
  endfunction

  function automatic int unsigned eff_samples();
    if (cfg_samples < 2) return 2;
    if (cfg_samples > MAX_SAMPLES_DEF) return MAX_SAMPLES_DEF;
    return cfg_samples;
  endfunction

  // fewer than four points, or a start past the last full window, is rejected
  function automatic bit segment_ok(input int unsigned start);
    int unsigned cnt;
    cnt = eff_points();
    if (cnt < 4) return 1'b0;
    if (cfg_closed) return start < cnt;
    return start <= cnt - 4;
  endfunction

  // exact numerator over 6 * 2^32, rounded half up to a q1.16 weight
  function automatic longint unsigned weight_q16(input longint unsigned num);
    return (num + (64'd3 << 32)) / (64'd6 << 32);
  endfunction

  // 29 fraction bits down to q2.13: add a half, floor, clamp
  function automatic logic signed [COORD_W-1:0] round_sat(input longint acc);
    longint v;
    v = (acc + 32768) >>> 16;
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    return v[COORD_W-1:0];
  endfunction

  // applies one accepted beat to the store and queues the curve beats it owes
  task automatic predict_curve(input seg_item_t it);
    int unsigned cnt, n, k, i, j;
    longint unsigned d, u, s, u2, u3;
    longint unsigned w [4];
    longint ax, ay;
    logic signed [COORD_W-1:0] px [4];
    logic signed [COORD_W-1:0] py [4];
    curve_beat_t r;
    if (it.op == OP_WRITE) begin
      pt_x[it.point_index] = it.coord_x;
      pt_y[it.point_index] = it.coord_y;
      pt_written[it.point_index] = 1'b1;
      return;
    end
    if (!segment_ok(it.segment_start)) begin
      r.curve_x = '0;
      r.curve_y = '0;
      r.valid_res = 1'b0;
      r.last = 1'b1;
      curve_exp_q.insert(curve_exp_q.size(), r);
      return;
    end
    cnt = eff_points();
    n = eff_samples();
    // four consecutive points, wrapping once past the end of the set in use
    for (i = 0; i < 4; i++) begin
      k = it.segment_start + i;
      if (k >= cnt) k -= cnt;
      px[i] = pt_x[k];
      py[i] = pt_y[k];
    end
    d = n - 1;
    for (j = 0; j < n; j++) begin
      u = (64'(j) * T_UNIT + (d >> 1)) / d;
      if (u > T_UNIT) u = T_UNIT;
      s = T_UNIT - u;
      u2 = u * u;
      u3 = u2 * u;
      // basis times 6 in q.48, kept exact until the weight rounding
      w[0] = weight_q16(s * s * s);
      w[1] = weight_q16(3 * u3 + (64'd4 << 48) - 6 * (u2 << 16));
      w[2] = weight_q16(3 * (u2 << 16) + 3 * (u << 32) + (64'd1 << 48) - 3 * u3);
      w[3] = weight_q16(u3);
      ax = 0;
      ay = 0;
      for (i = 0; i < 4; i++) begin
        ax += longint'(w[i]) * longint'(px[i]);
        ay += longint'(w[i]) * longint'(py[i]);
      end
      r.curve_x = round_sat(ax);
      r.curve_y = round_sat(ay);
      r.valid_res = 1'b1;
      r.last = (j == n - 1);
      curve_exp_q.insert(curve_exp_q.size(), r);
    end
  endtask

  // prints one line per mismatch and counts it
  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("[%0t] out beat %0d: %s got %0d, expected %0d",
             $realtime, out_beats, what, got, want);
  endtask

  // ------------------------------------------------------------------------
  // config port: setup cycle, then access cycle until pready
  // ------------------------------------------------------------------------
  task automatic cfg_write(input logic [1:0] reg_id, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_id, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (reg_id)
      REG_SAMPLE_COUNT: cfg_samples = value[CNT_W-1:0];
      REG_CLOSED_LOOP:  cfg_closed = value[0];
      REG_POINT_COUNT:  cfg_points = value[CNT_W-1:0];
      default: ;
    endcase
    // psel returns low between writes, so back to back writes start on a later edge
    @(posedge clk);
  endtask

  // ------------------------------------------------------------------------
  // input side: bursts of beats with random gaps between them
  // ------------------------------------------------------------------------
  task automatic send_item(input seg_item_t it, input bit reject_typed);
    curve_beat_t r;
    if (burst_left == 0) begin
      // valid was lowered at the last accept and stays low through the random gap
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 40)
                                                : $urandom_range(1, 8);
    end
    in_valid <= 1'b1;
    op <= it.op;
    point_index <= it.point_index;
    coord_x <= it.coord_x;
    coord_y <= it.coord_y;
    segment_start <= it.segment_start;
    // in_stall read right after the edge is still the value the edge saw
    do @(posedge clk); while (in_stall !== 1'b0);
    burst_left--;
    if (burst_left == 0) in_valid <= 1'b0;
    if (reject_typed) begin
      r.curve_x = '0;
      r.curve_y = '0;
      r.valid_res = 1'b0;
      r.last = 1'b1;
      curve_exp_q.insert(curve_exp_q.size(), r);
    end else begin
      predict_curve(it);
    end
  endtask

  // block idle: input quiet, every owed beat in, pipeline given time to drain
  task automatic wait_idle();
    if (burst_left != 0) begin
      in_valid <= 1'b0;
      burst_left = 0;
    end
    while (curve_exp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic dir_row_t row_write(input int idx, input int x, input int y);
    dir_row_t row;
    row.kind = ROW_ITEM;
    row.item.op = OP_WRITE;
    row.item.point_index = IDX_W'(idx);
    row.item.coord_x = COORD_W'(x);
    row.item.coord_y = COORD_W'(y);
    row.item.segment_start = IDX_W'($urandom);
    row.reject_typed = 1'b0;
    row.reg_id = REG_SAMPLE_COUNT;
    row.value = '0;
    return row;
  endfunction

  function automatic dir_row_t row_eval(input int start, input bit rej);
    dir_row_t row;
    row.kind = ROW_ITEM;
    row.item.op = OP_EVAL;
    row.item.point_index = IDX_W'($urandom);
    row.item.coord_x = COORD_W'($urandom);
    row.item.coord_y = COORD_W'($urandom);
    row.item.segment_start = IDX_W'(start);
    row.reject_typed = rej;
    row.reg_id = REG_SAMPLE_COUNT;
    row.value = '0;
    return row;
  endfunction

  function automatic dir_row_t row_cfg(input logic [1:0] reg_id, input int value);
    dir_row_t row;
    row = row_eval(0, 1'b0);
    row.kind = ROW_CFG;
    row.reg_id = reg_id;
    row.value = 32'(value);
    return row;
  endfunction

  // ------------------------------------------------------------------------
  // output side: stall pattern of its own, plus long hold-offs on request
  // ------------------------------------------------------------------------
  initial begin
    stall_mode_t mode;
    int mode_left, hold_left, hold_served;
    mode = STALL_NONE;
    mode_left = 0;
    hold_left = 0;
    hold_served = 0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_served < hold_asks) begin
        hold_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        // fills the pipeline so the block has to stall its input
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode = stall_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(20, 150);
        end
        mode_left--;
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 7) == 0);
          default:     out_stall <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  // score each accepted curve beat against the oldest expectation
  always @(posedge clk) begin
    curve_beat_t want;
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (curve_exp_q.size() == 0) begin
        flag_mismatch("beat with nothing owed, last", int'(last), 0);
      end else begin
        want = curve_exp_q.pop_front();
        if (curve_x !== want.curve_x)
          flag_mismatch("curve_x", int'(curve_x), int'(want.curve_x));
        if (curve_y !== want.curve_y)
          flag_mismatch("curve_y", int'(curve_y), int'(want.curve_y));
        if (valid_res !== want.valid_res)
          flag_mismatch("valid_res", int'(valid_res), int'(want.valid_res));
        if (last !== want.last) flag_mismatch("last", int'(last), int'(want.last));
      end
      out_beats++;
    end
  end

  // watchdog: too long with no beat accepted on either channel
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] no beat accepted for %0d cycles, %0d curve beats owed",
                 $realtime, WATCHDOG_LIMIT, curve_exp_q.size());
        $display("tb_cubic_bspline_segment_eval_core: FAIL");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------------
  initial begin
    dir_row_t    dir_rows [$];
    seg_item_t   it;
    int unsigned cnt, k;
    int          ph, n_item, i;
    bit          redirected;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: store reset state, extremes, both rejects, wrap, clamps
    dir_rows.insert(dir_rows.size(), row_eval(0, 1'b1));    // no points after reset
    dir_rows.insert(dir_rows.size(), row_write(0, 32767, -32768));
    dir_rows.insert(dir_rows.size(), row_write(1, -32768, 32767));
    dir_rows.insert(dir_rows.size(), row_write(2, 32767, 32767));
    dir_rows.insert(dir_rows.size(), row_write(3, -32768, -32768));
    dir_rows.insert(dir_rows.size(), row_write(63, 21845, -21846)); // 0x5555 / 0xaaaa
    dir_rows.insert(dir_rows.size(), row_write(62, -1, 1));
    dir_rows.insert(dir_rows.size(), row_write(60, 0, 0));
    dir_rows.insert(dir_rows.size(), row_write(61, 8192, -8192));
    dir_rows.insert(dir_rows.size(), row_cfg(REG_POINT_COUNT, 4));
    dir_rows.insert(dir_rows.size(), row_cfg(REG_SAMPLE_COUNT, 2)); // fewest samples
    dir_rows.insert(dir_rows.size(), row_eval(0, 1'b0));
    dir_rows.insert(dir_rows.size(), row_eval(1, 1'b1));    // open start past window
    dir_rows.insert(dir_rows.size(), row_eval(63, 1'b1));
    dir_rows.insert(dir_rows.size(), row_cfg(REG_CLOSED_LOOP, 1));
    dir_rows.insert(dir_rows.size(), row_eval(3, 1'b0));    // wraps 3,0,1,2
    dir_rows.insert(dir_rows.size(), row_eval(4, 1'b1));    // closed start at count
    dir_rows.insert(dir_rows.size(), row_cfg(REG_POINT_COUNT, 3));
    dir_rows.insert(dir_rows.size(), row_eval(0, 1'b1));    // too few points
    dir_rows.insert(dir_rows.size(), row_cfg(REG_POINT_COUNT, 127));  // acts as 64
    dir_rows.insert(dir_rows.size(), row_cfg(REG_SAMPLE_COUNT, 0));   // acts as 2
    dir_rows.insert(dir_rows.size(), row_eval(62, 1'b0));   // wraps 62,63,0,1
    dir_rows.insert(dir_rows.size(), row_cfg(REG_SAMPLE_COUNT, 127)); // acts as 64
    dir_rows.insert(dir_rows.size(), row_eval(63, 1'b0));
    dir_rows.insert(dir_rows.size(), row_cfg(REG_CLOSED_LOOP, 0));
    dir_rows.insert(dir_rows.size(), row_cfg(REG_SAMPLE_COUNT, 1));   // acts as 2
    dir_rows.insert(dir_rows.size(), row_eval(60, 1'b0));   // last legal open start
    dir_rows.insert(dir_rows.size(), row_eval(61, 1'b1));
    dir_rows.insert(dir_rows.size(), row_cfg(REG_SAMPLE_COUNT, 64));
    dir_rows.insert(dir_rows.size(), row_cfg(REG_POINT_COUNT, 64));
    dir_rows.insert(dir_rows.size(), row_eval(0, 1'b0));    // saturating extremes

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        wait_idle();
        cfg_write(dir_rows[r].reg_id, dir_rows[r].value);
      end else begin
        send_item(dir_rows[r].item, dir_rows[r].reject_typed);
      end
    end

    // random phases, each under its own register setting
    for (ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          cfg_write(REG_SAMPLE_COUNT, 64);
          cfg_write(REG_CLOSED_LOOP, 0);
          cfg_write(REG_POINT_COUNT, 64);
        end
        1: begin
          cfg_write(REG_SAMPLE_COUNT, $urandom_range(2, 12));
          cfg_write(REG_CLOSED_LOOP, 1);
          cfg_write(REG_POINT_COUNT, $urandom_range(4, 63));
        end
        2: begin
          cfg_write(REG_SAMPLE_COUNT, 0);
          cfg_write(REG_CLOSED_LOOP, 0);
          cfg_write(REG_POINT_COUNT, 127);
        end
        3: begin
          cfg_write(REG_SAMPLE_COUNT, 127);
          cfg_write(REG_CLOSED_LOOP, 1);
          cfg_write(REG_POINT_COUNT, 64);
        end
        4: begin
          // below four points every evaluation is rejected
          cfg_write(REG_SAMPLE_COUNT, $urandom_range(2, 64));
          cfg_write(REG_CLOSED_LOOP, $urandom_range(0, 1));
          cfg_write(REG_POINT_COUNT, $urandom_range(0, 3));
        end
        5: begin
          cfg_write(REG_SAMPLE_COUNT, 1);
          cfg_write(REG_CLOSED_LOOP, 1);
          cfg_write(REG_POINT_COUNT, 4);
        end
        default: begin
          cfg_write(REG_SAMPLE_COUNT, $urandom_range(2, 20));
          cfg_write(REG_CLOSED_LOOP, $urandom_range(0, 1));
          cfg_write(REG_POINT_COUNT, $urandom_range(4, 64));
        end
      endcase
      // long receiver hold-offs while the sender keeps offering beats
      if (ph == 0 || ph == 3) hold_asks++;

      cnt = eff_points();
      for (n_item = 0; n_item < PHASE_ITEMS; n_item++) begin
        it.op = ($urandom_range(0, 99) < 45) ? OP_WRITE : OP_EVAL;
        it.coord_x = ($urandom_range(0, 7) == 0) ?
                     ($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000) : 16'($urandom);
        it.coord_y = ($urandom_range(0, 7) == 0) ?
                     ($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000) : 16'($urandom);
        it.point_index = IDX_W'((cnt > 0 && $urandom_range(0, 9) < 6) ?
                                $urandom_range(0, cnt - 1) : $urandom_range(0, 63));
        // mostly starts inside the legal window, the rest anywhere
        if (cnt >= 4 && $urandom_range(0, 9) < 7)
          it.segment_start = IDX_W'(cfg_closed ? $urandom_range(0, cnt - 1)
                                               : $urandom_range(0, cnt - 4));
        else
          it.segment_start = IDX_W'($urandom_range(0, 63));
        // an evaluation that would touch a never-written entry fills it instead
        if (it.op == OP_EVAL && segment_ok(it.segment_start)) begin
          redirected = 1'b0;
          for (i = 0; i < 4; i++) begin
            k = it.segment_start + i;
            if (k >= cnt) k -= cnt;
            if (!pt_written[k] && !redirected) begin
              it.op = OP_WRITE;
              it.point_index = IDX_W'(k);
              redirected = 1'b1;
            end
          end
        end
        send_item(it, 1'b0);
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("tb_cubic_bspline_segment_eval_core: PASS");
    end else begin
      $display("tb_cubic_bspline_segment_eval_core: FAIL");
    end
    $finish;
  end

endmodule
